// ===== src/btss_pkg.sv =====
// Package for the board tag stream scanner: payload structs, register indexes,
// default sizes and the magic tag character table.
// No dependencies; imported by board_tag_stream_scanner_core.
package btss_pkg;

    // Default sizing of the scanner.
    localparam int NAME_CAPACITY_DEF = 32;
    localparam int MAGIC_CHARS_DEF   = 20;

    // Fixed character codes used by the scanner.
    localparam logic [7:0] CHAR_NAME_END   = 8'h3B;
    localparam logic [7:0] CHAR_PRINT_LOW  = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HIGH = 8'h7F;

    // Configuration register widths and reset values.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int EXP_LEN_W = 4;
    localparam int EXP_NAME_CHARS = 8;
    localparam logic [CFG_DATA_W-1:0] EXP_NAME_RESET = 64'd478660949112;
    localparam logic [EXP_LEN_W-1:0]  EXP_LEN_RESET  = 4'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_NAME   = 1'b0,
        CFG_EXPECTED_LENGTH = 1'b1
    } cfg_index_t;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic mismatch_found;
        logic in_name;
        logic chunk_done;
    } out_item_t;

    // Magic tag characters; positions past the tag length hold zero.
    localparam int MAGIC_TAB_DEPTH = 32;
    localparam logic [7:0] MAGIC_TAB [MAGIC_TAB_DEPTH] = '{
        8'h43, 8'h52, 8'h4F, 8'h53, 8'h53, 8'h50, 8'h4F, 8'h49,
        8'h4E, 8'h54, 8'h2D, 8'h42, 8'h4F, 8'h41, 8'h52, 8'h44,
        8'h2D, 8'h56, 8'h31, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

// ===== src/board_tag_stream_scanner_core.sv =====
// Board tag stream scanner top level: byte-wide tag search, name capture and
// on-the-fly name check. Depends on btss_pkg.
//
// The scanner takes one image byte per transaction and returns one result
// per byte in the cycle after the byte is accepted. It sustains one byte per
// clock: the whole decision for a byte is made in one pass of compare logic
// between the accepted input and a single result register, and s_ready stays
// high while that register is empty or its result is being taken in the same
// cycle. The result reports the sticky mismatch flag, whether name capture is
// active, and echoes chunk_end. Once a tag carrying a different name has been
// seen, the mismatch flag stays set and further bytes leave the state
// untouched until reset. Configuration writes take effect at once and must be
// issued only while no byte is in flight.
module board_tag_stream_scanner_core #(
    parameter int NAME_CAPACITY = btss_pkg::NAME_CAPACITY_DEF,
    parameter int MAGIC_CHARS   = btss_pkg::MAGIC_CHARS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input byte channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  btss_pkg::in_item_t                   s_data,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output btss_pkg::out_item_t                  m_data,
    // Configuration write port.
    input  logic                                 cfg_wr_en,
    input  logic [btss_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [btss_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import btss_pkg::*;

    localparam int COUNT_W = $clog2(NAME_CAPACITY + 1);
    localparam int PROG_W  = (MAGIC_CHARS > 1) ? $clog2(MAGIC_CHARS) : 1;
    localparam int CMP_W   = (COUNT_W > EXP_LEN_W) ? COUNT_W : EXP_LEN_W;
    localparam logic [PROG_W-1:0]  PROG_LAST = PROG_W'(MAGIC_CHARS - 1);
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(NAME_CAPACITY);
    localparam int NAME_SEL_W = $clog2(EXP_NAME_CHARS);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] expected_name_reg;
    logic [EXP_LEN_W-1:0]  expected_length_reg;

    // Scanner state.
    logic [PROG_W-1:0]  magic_progress_reg, magic_progress_next;
    logic               capture_active_reg, capture_active_next;
    logic [COUNT_W-1:0] name_count_reg, name_count_next;
    logic               name_equal_reg, name_equal_next;
    logic               mismatch_sticky_reg, mismatch_sticky_next;

    // Result register.
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    logic       in_accept;
    logic       out_accept;
    logic [7:0] magic_char;
    logic [7:0] expected_char;
    logic       char_matches;
    logic       printable;
    logic       length_ok;

    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;
    assign s_ready    = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_name_reg   <= EXP_NAME_RESET;
            expected_length_reg <= EXP_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECTED_NAME:   expected_name_reg   <= cfg_wdata;
                CFG_EXPECTED_LENGTH: expected_length_reg <= cfg_wdata[EXP_LEN_W-1:0];
            endcase
        end
    end

    // Per-byte compares against the magic table and the expected name.
    always_comb begin
        magic_char    = MAGIC_TAB[5'(magic_progress_reg)];
        expected_char = expected_name_reg[8*name_count_reg[NAME_SEL_W-1:0] +: 8];
        char_matches  = (name_count_reg < COUNT_W'(EXP_NAME_CHARS))
                        && (expected_char == s_data.data_byte);
        printable     = (s_data.data_byte > CHAR_PRINT_LOW)
                        && (s_data.data_byte < CHAR_PRINT_HIGH);
        length_ok     = (CMP_W'(name_count_reg) == CMP_W'(expected_length_reg));
    end

    // Next state for one accepted byte.
    always_comb begin
        magic_progress_next  = magic_progress_reg;
        capture_active_next  = capture_active_reg;
        name_count_next      = name_count_reg;
        name_equal_next      = name_equal_reg;
        mismatch_sticky_next = mismatch_sticky_reg;
        if (in_accept && !mismatch_sticky_reg) begin
            if (capture_active_reg) begin
                if (s_data.data_byte == CHAR_NAME_END) begin
                    capture_active_next = 1'b0;
                    if (!length_ok || !name_equal_reg) begin
                        mismatch_sticky_next = 1'b1;
                    end
                end else if ((name_count_reg < COUNT_CAP) && printable) begin
                    name_equal_next = name_equal_reg && char_matches;
                    name_count_next = name_count_reg + COUNT_W'(1);
                end else begin
                    capture_active_next = 1'b0;
                end
            end else if (s_data.data_byte == magic_char) begin
                if (magic_progress_reg == PROG_LAST) begin
                    magic_progress_next = '0;
                    capture_active_next = 1'b1;
                    name_count_next     = '0;
                    name_equal_next     = 1'b1;
                end else begin
                    magic_progress_next = magic_progress_reg + PROG_W'(1);
                end
            end else if (s_data.data_byte == MAGIC_TAB[0]) begin
                // Lookback restart: this byte may open a new tag.
                magic_progress_next = PROG_W'(1 % MAGIC_CHARS);
            end else begin
                magic_progress_next = '0;
            end
        end
    end

    // Result register occupancy.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_accept) begin
            out_valid_next = 1'b1;
        end else if (out_accept) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_progress_reg  <= '0;
            capture_active_reg  <= 1'b0;
            name_count_reg      <= '0;
            name_equal_reg      <= 1'b1;
            mismatch_sticky_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            magic_progress_reg  <= magic_progress_next;
            capture_active_reg  <= capture_active_next;
            name_count_reg      <= name_count_next;
            name_equal_reg      <= name_equal_next;
            mismatch_sticky_reg <= mismatch_sticky_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload, loaded with the state after each accepted byte.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg.mismatch_found <= mismatch_sticky_next;
            out_data_reg.in_name        <= capture_active_next;
            out_data_reg.chunk_done     <= s_data.chunk_end;
        end
    end

`ifndef SYNTH
    // Once set, the mismatch flag never clears before reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mismatch_sticky_reg |=> mismatch_sticky_reg)
        else $error("mismatch flag cleared without reset");

    // A mismatch ends capture for good.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mismatch_sticky_reg |-> !capture_active_reg)
        else $error("capture active after mismatch");

    // Magic search is parked at zero while a name is captured.
    assert property (@(posedge aclk) disable iff (!aresetn)
        capture_active_reg |-> (magic_progress_reg == '0))
        else $error("magic progress nonzero during capture");

    // The name count never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        name_count_reg <= COUNT_CAP)
        else $error("name count beyond capacity");
`endif

endmodule
